@@ rtl/jts_pkg.sv @@
// Shared types, constants and the microcode table of the joint trajectory
// time-scaling block. No dependencies.
`default_nettype none

package jts_pkg;

    // Sizes
    localparam int MAX_POINTS = 64;
    localparam int POS_W      = 32;                      // Q16.16 position
    localparam int FRAC_W     = 24;                      // fraction bits of s
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);  // point count
    localparam int IDX_W      = $clog2(MAX_POINTS);      // point index
    localparam int SPAN_W     = POS_W + 1;               // end - start
    localparam int MAG_W      = POS_W;                   // |span| < 2^POS_W
    localparam int QUO_W      = FRAC_W + 1;              // s in [0, 1.0]
    localparam int PROD_W     = MAG_W + QUO_W;
    localparam int DATA_W     = 32;                      // scratch registers
    localparam int NUM_W      = 30;                      // (MAX_POINTS-1)^5 fits
    localparam int REM_W      = NUM_W + 1;
    localparam int DIVC_W     = $clog2(QUO_W);
    localparam int MODE_W     = 2;
    localparam int UADDR_W    = 5;
    localparam int K_W        = 4;

    // Scaling modes; any other code behaves as none
    localparam logic [MODE_W-1:0] MODE_CUBIC   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_QUINTIC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NONE    = 2'd2;

    // Immediate constants
    localparam logic [K_W-1:0] K_ZERO    = 4'd0;
    localparam logic [K_W-1:0] K_ONE     = 4'd1;
    localparam logic [K_W-1:0] K_TWO     = 4'd2;
    localparam logic [K_W-1:0] K_THREE   = 4'd3;
    localparam logic [K_W-1:0] K_SIX     = 4'd6;
    localparam logic [K_W-1:0] K_TEN     = 4'd10;
    localparam logic [K_W-1:0] K_FIFTEEN = 4'd15;

    // Microcode entry points
    localparam logic [UADDR_W-1:0] A_IDLE  = 5'd0;
    localparam logic [UADDR_W-1:0] A_ERR   = 5'd1;
    localparam logic [UADDR_W-1:0] A_CUB   = 5'd2;
    localparam logic [UADDR_W-1:0] A_QUI   = 5'd9;
    localparam logic [UADDR_W-1:0] A_NONE  = 5'd21;
    localparam logic [UADDR_W-1:0] A_DIV   = 5'd23;
    localparam logic [UADDR_W-1:0] A_DSTEP = 5'd24;
    localparam logic [UADDR_W-1:0] A_SCALE = 5'd25;
    localparam logic [UADDR_W-1:0] A_EMIT  = 5'd26;
    localparam logic [UADDR_W-1:0] A_LAST  = A_EMIT;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_MUL,
        OP_ADD,
        OP_SUB,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_SCALE,
        OP_EMIT,
        OP_EMIT_ERR
    } t_op;

    typedef enum logic [2:0] {
        J_SEQ,
        J_GOTO,
        J_IDLE,
        J_LOOP,
        J_WAIT_END,
        J_EMIT
    } t_jmp;

    typedef enum logic [1:0] {
        RD_R0,
        RD_R1,
        RD_R2,
        RD_R3
    } t_dst;

    typedef enum logic [2:0] {
        SEL_R0,
        SEL_R1,
        SEL_R2,
        SEL_R3,
        SEL_I,
        SEL_M,
        SEL_K
    } t_sel;

    typedef struct packed {
        t_op                 op;
        t_jmp                jmp;
        t_dst                dst;
        t_sel                sel_a;
        t_sel                sel_b;
        logic [K_W-1:0]      k;
        logic [UADDR_W-1:0]  target;
    } t_uop;

    typedef struct packed {
        logic start;
        logic start_err;
        logic div_more;
        logic last;
        logic out_free;
    } t_seq_stat;

    typedef struct packed {
        logic signed [POS_W-1:0] position;
        logic [IDX_W-1:0]        point_index;
        logic                    last;
        logic                    error;
    } t_point;

    function automatic t_uop uw(input t_op op, input t_jmp jmp, input t_dst dst,
                                input t_sel a, input t_sel b,
                                input logic [K_W-1:0] k,
                                input logic [UADDR_W-1:0] tgt);
        t_uop w;
        w.op     = op;
        w.jmp    = jmp;
        w.dst    = dst;
        w.sel_a  = a;
        w.sel_b  = b;
        w.k      = k;
        w.target = tgt;
        return w;
    endfunction

    // Control store. R0 = numerator, R1 = denominator on entry to the divider.
    function automatic t_uop urom(input logic [UADDR_W-1:0] addr);
        t_uop w;
        case (addr)
            A_IDLE: w = uw(OP_NOP, J_IDLE, RD_R0, SEL_K, SEL_K, K_ZERO, A_IDLE);
            A_ERR:  w = uw(OP_EMIT_ERR, J_WAIT_END, RD_R0, SEL_K, SEL_K, K_ZERO, A_IDLE);
            // cubic: num = i^2 (3m - 2i), den = m^3
            A_CUB:  w = uw(OP_MUL, J_SEQ, RD_R0, SEL_I, SEL_I, K_ZERO, A_IDLE);
            A_CUB + UADDR_W'(1):
                w = uw(OP_MUL, J_SEQ, RD_R1, SEL_M, SEL_K, K_THREE, A_IDLE);
            A_CUB + UADDR_W'(2):
                w = uw(OP_MUL, J_SEQ, RD_R2, SEL_I, SEL_K, K_TWO, A_IDLE);
            A_CUB + UADDR_W'(3):
                w = uw(OP_SUB, J_SEQ, RD_R1, SEL_R1, SEL_R2, K_ZERO, A_IDLE);
            A_CUB + UADDR_W'(4):
                w = uw(OP_MUL, J_SEQ, RD_R0, SEL_R0, SEL_R1, K_ZERO, A_IDLE);
            A_CUB + UADDR_W'(5):
                w = uw(OP_MUL, J_SEQ, RD_R1, SEL_M, SEL_M, K_ZERO, A_IDLE);
            A_CUB + UADDR_W'(6):
                w = uw(OP_MUL, J_GOTO, RD_R1, SEL_R1, SEL_M, K_ZERO, A_DIV);
            // quintic: num = i^3 (10m^2 + 6i^2 - 15im), den = m^5
            A_QUI:  w = uw(OP_MUL, J_SEQ, RD_R0, SEL_I, SEL_I, K_ZERO, A_IDLE);
            A_QUI + UADDR_W'(1):
                w = uw(OP_MUL, J_SEQ, RD_R1, SEL_R0, SEL_I, K_ZERO, A_IDLE);
            A_QUI + UADDR_W'(2):
                w = uw(OP_MUL, J_SEQ, RD_R2, SEL_M, SEL_M, K_ZERO, A_IDLE);
            A_QUI + UADDR_W'(3):
                w = uw(OP_MUL, J_SEQ, RD_R3, SEL_R2, SEL_K, K_TEN, A_IDLE);
            A_QUI + UADDR_W'(4):
                w = uw(OP_MUL, J_SEQ, RD_R0, SEL_R0, SEL_K, K_SIX, A_IDLE);
            A_QUI + UADDR_W'(5):
                w = uw(OP_ADD, J_SEQ, RD_R3, SEL_R3, SEL_R0, K_ZERO, A_IDLE);
            A_QUI + UADDR_W'(6):
                w = uw(OP_MUL, J_SEQ, RD_R0, SEL_I, SEL_M, K_ZERO, A_IDLE);
            A_QUI + UADDR_W'(7):
                w = uw(OP_MUL, J_SEQ, RD_R0, SEL_R0, SEL_K, K_FIFTEEN, A_IDLE);
            A_QUI + UADDR_W'(8):
                w = uw(OP_SUB, J_SEQ, RD_R3, SEL_R3, SEL_R0, K_ZERO, A_IDLE);
            A_QUI + UADDR_W'(9):
                w = uw(OP_MUL, J_SEQ, RD_R0, SEL_R1, SEL_R3, K_ZERO, A_IDLE);
            A_QUI + UADDR_W'(10):
                w = uw(OP_MUL, J_SEQ, RD_R1, SEL_R2, SEL_R2, K_ZERO, A_IDLE);
            A_QUI + UADDR_W'(11):
                w = uw(OP_MUL, J_GOTO, RD_R1, SEL_R1, SEL_M, K_ZERO, A_DIV);
            // none: num = 0, den = m
            A_NONE: w = uw(OP_MUL, J_SEQ, RD_R0, SEL_I, SEL_K, K_ZERO, A_IDLE);
            A_NONE + UADDR_W'(1):
                w = uw(OP_MUL, J_SEQ, RD_R1, SEL_M, SEL_K, K_ONE, A_IDLE);
            A_DIV:   w = uw(OP_DIV_INIT, J_SEQ, RD_R0, SEL_K, SEL_K, K_ZERO, A_IDLE);
            A_DSTEP: w = uw(OP_DIV_STEP, J_LOOP, RD_R0, SEL_K, SEL_K, K_ZERO, A_DSTEP);
            A_SCALE: w = uw(OP_SCALE, J_SEQ, RD_R0, SEL_K, SEL_K, K_ZERO, A_IDLE);
            A_EMIT:  w = uw(OP_EMIT, J_EMIT, RD_R0, SEL_K, SEL_K, K_ZERO, A_IDLE);
            default: w = uw(OP_NOP, J_GOTO, RD_R0, SEL_K, SEL_K, K_ZERO, A_IDLE);
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/jts_req_if.sv @@
// Request channel: start/end position, duration and point count.
// Depends on jts_pkg.
`default_nettype none

interface jts_req_if;
    logic                                valid;
    logic                                ready;
    logic signed [jts_pkg::POS_W-1:0]    start_position;
    logic signed [jts_pkg::POS_W-1:0]    end_position;
    logic [jts_pkg::POS_W-1:0]           duration;
    logic [jts_pkg::CNT_W-1:0]           point_count;

    modport source (output valid, start_position, end_position, duration, point_count,
                    input ready);
    modport sink   (input valid, start_position, end_position, duration, point_count,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/jts_pt_if.sv @@
// Trajectory point channel: position, index, last and error flags.
// Depends on jts_pkg.
`default_nettype none

interface jts_pt_if;
    logic                                valid;
    logic                                ready;
    logic signed [jts_pkg::POS_W-1:0]    position;
    logic [jts_pkg::IDX_W-1:0]           point_index;
    logic                                last;
    logic                                error;

    modport source (output valid, position, point_index, last, error, input ready);
    modport sink   (input valid, position, point_index, last, error, output ready);
endinterface

`default_nettype wire

@@ rtl/jts_dpath.sv @@
// Datapath: scratch registers with one multiply/add unit, bit-serial
// divider, span scaling and point formation. Depends on jts_pkg.
`default_nettype none

module jts_dpath (
    input  logic                               i_clk,
    input  logic                               i_load,
    input  logic signed [jts_pkg::POS_W-1:0]   i_start_pos,
    input  logic signed [jts_pkg::POS_W-1:0]   i_end_pos,
    input  logic [jts_pkg::CNT_W-1:0]          i_count,
    input  jts_pkg::t_uop                      i_uop,
    input  logic                               i_emit,
    output jts_pkg::t_point                    o_point,
    output logic                               o_div_more,
    output logic                               o_last
);

    logic [jts_pkg::POS_W-1:0]   r_start;
    logic                        r_neg;
    logic [jts_pkg::MAG_W-1:0]   r_mag;
    logic [jts_pkg::IDX_W-1:0]   r_i;
    logic [jts_pkg::IDX_W-1:0]   r_m;
    logic [jts_pkg::DATA_W-1:0]  r_r0, r_r1, r_r2, r_r3;
    logic [jts_pkg::REM_W-1:0]   r_rem;
    logic [jts_pkg::QUO_W-1:0]   r_quo;
    logic [jts_pkg::DIVC_W-1:0]  r_dcnt;
    logic [jts_pkg::PROD_W-1:0]  r_prod;

    logic [jts_pkg::SPAN_W-1:0]  w_span;
    logic [jts_pkg::SPAN_W-1:0]  w_span_mag;
    logic [jts_pkg::DATA_W-1:0]  w_a, w_b, w_alu;
    logic                        w_alu_we;
    logic [jts_pkg::REM_W-1:0]   w_den;
    logic                        w_ge;
    logic [jts_pkg::REM_W-1:0]   w_diff;
    logic [jts_pkg::PROD_W-1:0]  w_prod;
    logic [jts_pkg::SPAN_W-1:0]  w_delta, w_sdelta, w_sum;

    function automatic logic [jts_pkg::DATA_W-1:0] f_operand(
        input jts_pkg::t_sel sel,
        input logic [jts_pkg::DATA_W-1:0] r0, r1, r2, r3,
        input logic [jts_pkg::IDX_W-1:0] i, m,
        input logic [jts_pkg::K_W-1:0] k);
        logic [jts_pkg::DATA_W-1:0] v;
        case (sel)
            jts_pkg::SEL_R0: v = r0;
            jts_pkg::SEL_R1: v = r1;
            jts_pkg::SEL_R2: v = r2;
            jts_pkg::SEL_R3: v = r3;
            jts_pkg::SEL_I:  v = jts_pkg::DATA_W'(i);
            jts_pkg::SEL_M:  v = jts_pkg::DATA_W'(m);
            jts_pkg::SEL_K:  v = jts_pkg::DATA_W'(k);
            default:         v = '0;
        endcase
        return v;
    endfunction

    // span as 33-bit two's complement, then its magnitude (always < 2^32)
    assign w_span     = {i_end_pos[jts_pkg::POS_W-1], i_end_pos}
                      - {i_start_pos[jts_pkg::POS_W-1], i_start_pos};
    assign w_span_mag = w_span[jts_pkg::SPAN_W-1] ? (~w_span + jts_pkg::SPAN_W'(1)) : w_span;

    assign w_a = f_operand(i_uop.sel_a, r_r0, r_r1, r_r2, r_r3, r_i, r_m, i_uop.k);
    assign w_b = f_operand(i_uop.sel_b, r_r0, r_r1, r_r2, r_r3, r_i, r_m, i_uop.k);

    always_comb begin
        w_alu    = '0;
        w_alu_we = 1'b0;
        case (i_uop.op)
            jts_pkg::OP_MUL: begin
                w_alu    = w_a * w_b;
                w_alu_we = 1'b1;
            end
            jts_pkg::OP_ADD: begin
                w_alu    = w_a + w_b;
                w_alu_we = 1'b1;
            end
            jts_pkg::OP_SUB: begin
                w_alu    = w_a - w_b;
                w_alu_we = 1'b1;
            end
            default: begin
                w_alu    = '0;
                w_alu_we = 1'b0;
            end
        endcase
    end

    // restoring divide: one quotient bit per step, MSB (integer bit) first
    assign w_den  = r_r1[jts_pkg::REM_W-1:0];
    assign w_ge   = r_rem >= w_den;
    assign w_diff = w_ge ? (r_rem - w_den) : r_rem;

    assign w_prod = jts_pkg::PROD_W'(r_mag) * jts_pkg::PROD_W'(r_quo);

    // truncate |span|*s, restore sign, add start
    assign w_delta  = r_prod[jts_pkg::PROD_W-1:jts_pkg::FRAC_W];
    assign w_sdelta = r_neg ? (~w_delta + jts_pkg::SPAN_W'(1)) : w_delta;
    assign w_sum    = {r_start[jts_pkg::POS_W-1], r_start} + w_sdelta;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_start <= i_start_pos;
            r_neg   <= w_span[jts_pkg::SPAN_W-1];
            r_mag   <= w_span_mag[jts_pkg::MAG_W-1:0];
            r_i     <= '0;
            r_m     <= jts_pkg::IDX_W'(i_count - jts_pkg::CNT_W'(1));
        end else if (i_emit && i_uop.op == jts_pkg::OP_EMIT) begin
            r_i <= r_i + jts_pkg::IDX_W'(1);
        end

        if (w_alu_we) begin
            case (i_uop.dst)
                jts_pkg::RD_R0: r_r0 <= w_alu;
                jts_pkg::RD_R1: r_r1 <= w_alu;
                jts_pkg::RD_R2: r_r2 <= w_alu;
                jts_pkg::RD_R3: r_r3 <= w_alu;
                default:        r_r0 <= w_alu;
            endcase
        end

        case (i_uop.op)
            jts_pkg::OP_DIV_INIT: begin
                r_rem  <= jts_pkg::REM_W'(r_r0[jts_pkg::NUM_W-1:0]);
                r_quo  <= '0;
                r_dcnt <= jts_pkg::DIVC_W'(jts_pkg::QUO_W - 1);
            end
            jts_pkg::OP_DIV_STEP: begin
                r_rem  <= {w_diff[jts_pkg::REM_W-2:0], 1'b0};
                r_quo  <= {r_quo[jts_pkg::QUO_W-2:0], w_ge};
                r_dcnt <= r_dcnt - jts_pkg::DIVC_W'(1);
            end
            jts_pkg::OP_SCALE: begin
                r_prod <= w_prod;
            end
            default: begin
                r_dcnt <= r_dcnt;
            end
        endcase
    end

    assign o_div_more = r_dcnt != '0;
    assign o_last     = r_i == r_m;

    always_comb begin
        if (i_uop.op == jts_pkg::OP_EMIT_ERR) begin
            o_point.position    = r_start;
            o_point.point_index = '0;
            o_point.last        = 1'b1;
            o_point.error       = 1'b1;
        end else begin
            o_point.position    = w_sum[jts_pkg::POS_W-1:0];
            o_point.point_index = r_i;
            o_point.last        = o_last;
            o_point.error       = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/jts_useq.sv @@
// Microcode sequencer: step counter, control store lookup, jump logic.
// Depends on jts_pkg.
`default_nettype none

module jts_useq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [jts_pkg::MODE_W-1:0]     i_mode,
    input  jts_pkg::t_seq_stat             i_stat,
    output jts_pkg::t_uop                  o_uop,
    output logic                           o_idle
);

    logic [jts_pkg::UADDR_W-1:0] r_pc;
    logic [jts_pkg::UADDR_W-1:0] n_pc;
    logic [jts_pkg::UADDR_W-1:0] w_dispatch;
    jts_pkg::t_uop               w_uop;

    assign w_uop = jts_pkg::urom(r_pc);

    // per-point program start by mode; unused mode code runs as none
    always_comb begin
        case (i_mode)
            jts_pkg::MODE_CUBIC:   w_dispatch = jts_pkg::A_CUB;
            jts_pkg::MODE_QUINTIC: w_dispatch = jts_pkg::A_QUI;
            default:               w_dispatch = jts_pkg::A_NONE;
        endcase
    end

    always_comb begin
        n_pc = r_pc;
        case (w_uop.jmp)
            jts_pkg::J_SEQ:  n_pc = r_pc + jts_pkg::UADDR_W'(1);
            jts_pkg::J_GOTO: n_pc = w_uop.target;
            jts_pkg::J_IDLE: begin
                if (i_stat.start) begin
                    n_pc = i_stat.start_err ? jts_pkg::A_ERR : w_dispatch;
                end
            end
            jts_pkg::J_LOOP: begin
                n_pc = i_stat.div_more ? w_uop.target : r_pc + jts_pkg::UADDR_W'(1);
            end
            jts_pkg::J_WAIT_END: begin
                if (i_stat.out_free) begin
                    n_pc = jts_pkg::A_IDLE;
                end
            end
            jts_pkg::J_EMIT: begin
                if (i_stat.out_free) begin
                    n_pc = i_stat.last ? jts_pkg::A_IDLE : w_dispatch;
                end
            end
            default: n_pc = jts_pkg::A_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= jts_pkg::A_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_uop  = w_uop;
    assign o_idle = r_pc == jts_pkg::A_IDLE;

    a_pc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pc <= jts_pkg::A_LAST)
        else $error("step counter outside control store");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uop.op == jts_pkg::OP_DIV_STEP && !i_stat.div_more)
        |=> (w_uop.op == jts_pkg::OP_SCALE))
        else $error("divider loop did not exit to scaling");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_uop.op == jts_pkg::OP_EMIT && i_stat.out_free && i_stat.last)
        |=> (r_pc == jts_pkg::A_IDLE))
        else $error("run did not end after last point");

endmodule

`default_nettype wire

@@ rtl/joint_trajectory_time_scaling.sv @@
// Top level of the joint trajectory time-scaling block: request/point
// channels, mode register, output register. Depends on jts_pkg, jts_req_if,
// jts_pt_if, jts_useq and jts_dpath.
//
// Usage
//   i_req carries one request beat: start/end position (signed Q16.16),
//   duration (checked only for zero) and point count N (saturated to 64).
//   o_pt returns N point beats, index 0..N-1, last set on the final one.
//   N = 0 gives no beat. Zero duration or N = 1 gives one beat holding the
//   start position with error and last set.
//   i_cfg_we/i_cfg_data write the scaling mode (0 cubic, 1 quintic,
//   2 or 3 none); write it only while no request is in flight.
// Operation
//   A request beat is taken only while the sequencer is idle. Each point is
//   one pass of the microprogram: the polynomial steps on the shared
//   multiplier, 25 divider steps, one scaling multiply, one emit step. A
//   request of N points holds the block until its last point is emitted;
//   the first point enters the output register at the emit step of the
//   first pass. An error request runs the single error-emit step and then
//   returns to idle.
// Stall and reset
//   The emit step loads the output register whenever it is empty or being
//   drained; otherwise the sequencer waits on that step, so a stalled
//   receiver loses nothing. Reset (synchronous, active low) returns the
//   sequencer to idle, empties the output register and sets mode to cubic.
`default_nettype none

module joint_trajectory_time_scaling (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [jts_pkg::MODE_W-1:0]    i_cfg_data,
    jts_req_if.sink                       i_req,
    jts_pt_if.source                      o_pt
);

    logic [jts_pkg::MODE_W-1:0]  r_mode;
    logic                        r_out_valid;
    jts_pkg::t_point             r_point;

    logic [jts_pkg::CNT_W-1:0]   w_count;
    logic                        w_fire;
    logic                        w_idle;
    logic                        w_out_free;
    logic                        w_emit;
    logic                        w_div_more;
    logic                        w_last;
    jts_pkg::t_uop               w_uop;
    jts_pkg::t_seq_stat          w_stat;
    jts_pkg::t_point             w_point;

    // counts above the maximum are clamped
    assign w_count = (i_req.point_count > jts_pkg::CNT_W'(jts_pkg::MAX_POINTS))
                   ? jts_pkg::CNT_W'(jts_pkg::MAX_POINTS) : i_req.point_count;

    assign i_req.ready = w_idle;
    assign w_fire      = i_req.valid && i_req.ready;

    // output register can take a beat this cycle
    assign w_out_free = !r_out_valid || o_pt.ready;
    assign w_emit     = (w_uop.op == jts_pkg::OP_EMIT || w_uop.op == jts_pkg::OP_EMIT_ERR)
                      && w_out_free;

    always_comb begin
        w_stat.start     = w_fire && (w_count != '0);
        w_stat.start_err = (i_req.duration == '0) || (w_count == jts_pkg::CNT_W'(1));
        w_stat.div_more  = w_div_more;
        w_stat.last      = w_last;
        w_stat.out_free  = w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= jts_pkg::MODE_CUBIC;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_data;
        end
    end

    jts_useq u_useq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_stat  (w_stat),
        .o_uop   (w_uop),
        .o_idle  (w_idle)
    );

    jts_dpath u_dpath (
        .i_clk       (i_clk),
        .i_load      (w_fire),
        .i_start_pos (i_req.start_position),
        .i_end_pos   (i_req.end_position),
        .i_count     (w_count),
        .i_uop       (w_uop),
        .i_emit      (w_emit),
        .o_point     (w_point),
        .o_div_more  (w_div_more),
        .o_last      (w_last)
    );

    // output register: parts the sequencer from the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (o_pt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_point <= w_point;
        end
    end

    assign o_pt.valid       = r_out_valid;
    assign o_pt.position    = r_point.position;
    assign o_pt.point_index = r_point.point_index;
    assign o_pt.last        = r_point.last;
    assign o_pt.error       = r_point.error;

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pt.valid && o_pt.error) |-> (o_pt.last && o_pt.point_index == '0))
        else $error("error beat must be a single point");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && i_req.point_count != '0) |=> !i_req.ready)
        else $error("request taken while a run is active");

    a_pt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pt.valid && !o_pt.ready) |=> (o_pt.valid && $stable(r_point)))
        else $error("point beat changed while stalled");

endmodule

`default_nettype wire
